>>> rtl/modinv_pkg.sv
// package for the modular inverse block
// holds the state encoding, status codes and default width; no dependencies
`default_nettype none

package modinv_pkg;

    // default operand width in bits
    localparam int MI_WIDTH = 32;

    // width of the operand and result fields on the ports
    localparam int FIELD_W = 32;

    // status codes carried in the result word
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_WAIT,
        ST_FIN,
        ST_DONE
    } t_state;

    // control into the divide/accumulate unit
    typedef struct packed {
        logic start;
    } t_div_req;

    // status out of the divide/accumulate unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

>>> rtl/modinv_divacc.sv
// shared bit-serial unit for one euclid step: restoring division of r0 by r1
// with a shift-add of the quotient times t1 alongside; uses modinv_pkg
`default_nettype none

module modinv_divacc #(
    parameter int DW = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  modinv_pkg::t_div_req   i_req,
    input  wire  [DW-1:0]          i_dividend,
    input  wire  [DW-1:0]          i_divisor,
    input  wire  [DW-1:0]          i_coef,
    output modinv_pkg::t_div_sts   o_sts,
    output logic [DW-1:0]          o_rem,
    output logic [DW-1:0]          o_acc
);

    localparam int CW = $clog2(DW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [DW-1:0] r_dvs, n_dvs;
    logic [DW-1:0] r_tm, n_tm;
    logic [DW-1:0] r_acc, n_acc;

    logic [DW:0]   w_rem_sh;
    logic [DW:0]   w_diff;
    logic          w_qbit;

    // one quotient bit per cycle, partial product follows the same bit
    assign w_rem_sh = {r_rem, r_dvd[DW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_qbit   = ~w_diff[DW];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_tm   = r_tm;
        n_acc  = r_acc;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW - 1);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_tm   = i_coef;
            n_acc  = '0;
        end else if (r_busy) begin
            n_rem = w_qbit ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            n_dvd = {r_dvd[DW-2:0], 1'b0};
            n_acc = {r_acc[DW-2:0], 1'b0} + (w_qbit ? r_tm : '0);
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state resets, datapath does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_tm  <= n_tm;
        r_acc <= n_acc;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;
    assign o_acc      = r_acc;

endmodule

`default_nettype wire

>>> rtl/modular_inverse.sv
// modular inverse by extended euclid: one word in, one result word out.
// the euclid step count is at most about 46 for 32-bit operands.
// bad operands (equal or zero) give a result without running any euclid step.
// one word at a time; the next word can be accepted in the same cycle the result is valid.
// synchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module modular_inverse #(
    parameter int WIDTH = modinv_pkg::MI_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // inverse [31:0]
    output logic        o_m_tuser    // status [0]
);

    localparam int FW = modinv_pkg::FIELD_W;
    localparam int DW = (WIDTH < FW) ? WIDTH : FW;

    modinv_pkg::t_state r_state, n_state;

    logic [DW-1:0] r_m, n_m;
    logic [DW-1:0] r_r0, n_r0;
    logic [DW-1:0] r_r1, n_r1;
    logic [DW-1:0] r_t0, n_t0;
    logic [DW-1:0] r_t1, n_t1;
    logic          r_neg0, n_neg0;
    logic          r_neg1, n_neg1;
    logic [DW-1:0] r_res_inv, n_res_inv;
    logic          r_res_st, n_res_st;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_inv, n_out_inv;
    logic          r_out_st, n_out_st;

    logic [DW-1:0] w_a, w_b, w_big, w_sml;
    logic          w_bad, w_accept, w_out_free;
    logic [DW-1:0] w_red;

    modinv_pkg::t_div_req w_req;
    modinv_pkg::t_div_sts w_sts;
    logic [DW-1:0]        w_rem, w_acc;

    // operands masked to the working width
    assign w_a      = i_s_tdata[DW-1:0];
    assign w_b      = i_s_tdata[FW+DW-1:FW];
    assign w_big    = (w_a > w_b) ? w_a : w_b;
    assign w_sml    = (w_a > w_b) ? w_b : w_a;
    assign w_bad    = (w_a == w_b) || (w_a == '0) || (w_b == '0);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // final coefficient is at most m, so reducing is a single equality check
    assign w_red = (r_t0 == r_m) ? '0 : r_t0;

    modinv_divacc #(
        .DW (DW)
    ) u_divacc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (r_r0),
        .i_divisor  (r_r1),
        .i_coef     (r_t1),
        .o_sts      (w_sts),
        .o_rem      (w_rem),
        .o_acc      (w_acc)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            modinv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad ? modinv_pkg::ST_DONE : modinv_pkg::ST_STEP;
                end
            end
            modinv_pkg::ST_STEP: begin
                n_state = modinv_pkg::ST_WAIT;
            end
            modinv_pkg::ST_WAIT: begin
                if (w_sts.done) begin
                    n_state = (w_rem == '0) ? modinv_pkg::ST_FIN : modinv_pkg::ST_STEP;
                end
            end
            modinv_pkg::ST_FIN: begin
                n_state = modinv_pkg::ST_DONE;
            end
            modinv_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = modinv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = modinv_pkg::ST_IDLE;
            end
        endcase
    end

    // state decoded outputs
    always_comb begin
        o_s_tready  = (r_state == modinv_pkg::ST_IDLE);
        w_req.start = (r_state == modinv_pkg::ST_STEP);
    end

    // euclid registers, result and output word
    always_comb begin
        n_m         = r_m;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_neg0      = r_neg0;
        n_neg1      = r_neg1;
        n_res_inv   = r_res_inv;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out_inv   = r_out_inv;
        n_out_st    = r_out_st;

        // load a new word
        if (r_state == modinv_pkg::ST_IDLE && w_accept) begin
            n_m       = w_big;
            n_r0      = w_big;
            n_r1      = w_sml;
            n_t0      = '0;
            n_t1      = DW'(1);
            n_neg0    = 1'b0;
            n_neg1    = 1'b0;
            n_res_inv = '0;
            n_res_st  = modinv_pkg::STATUS_NONE;
        end

        // retire one euclid step; new coefficient is t0 + q * t1, signs alternate
        if (r_state == modinv_pkg::ST_WAIT && w_sts.done) begin
            n_r0   = r_r1;
            n_r1   = w_rem;
            n_t0   = r_t1;
            n_t1   = w_acc + r_t0;
            n_neg0 = r_neg1;
            n_neg1 = ~r_neg1;
        end

        // gcd check and sign fix
        if (r_state == modinv_pkg::ST_FIN) begin
            if (r_r0 == DW'(1)) begin
                n_res_inv = (r_neg0 && w_red != '0) ? (r_m - w_red) : w_red;
                n_res_st  = modinv_pkg::STATUS_OK;
            end else begin
                n_res_inv = '0;
                n_res_st  = modinv_pkg::STATUS_NONE;
            end
        end

        // output register
        if (r_state == modinv_pkg::ST_DONE && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_inv   = r_res_inv;
            n_out_st    = r_res_st;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= modinv_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_m       <= n_m;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_t0      <= n_t0;
        r_t1      <= n_t1;
        r_neg0    <= n_neg0;
        r_neg1    <= n_neg1;
        r_res_inv <= n_res_inv;
        r_res_st  <= n_res_st;
        r_out_inv <= n_out_inv;
        r_out_st  <= n_out_st;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = FW'(r_out_inv);
    assign o_m_tuser  = r_out_st;

    // a failed word always carries a zero inverse
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == modinv_pkg::STATUS_NONE) |-> (o_m_tdata == '0))
        else $error("no-inverse word with nonzero data");

    // a found inverse lies below the modulus
    a_inv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == modinv_pkg::ST_DONE && r_res_st == modinv_pkg::STATUS_OK)
        |-> (r_res_inv < r_m))
        else $error("inverse not reduced below modulus");

    // the unit finishes only while the sequencer waits on it
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == modinv_pkg::ST_WAIT))
        else $error("divide unit done outside wait state");

    // an accepted word leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != modinv_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accept");

endmodule

`default_nettype wire
